[rtl/avd_pkg.sv]
// ----------------------------------------------------------------------------
// Average velocity conversion package
// Shared widths, register indexes, sequencer states and control structures
// for the interval-to-average velocity converter.
// ----------------------------------------------------------------------------
package avd_pkg;

    // Field widths.
    localparam int VEL_W      = 24;   // velocity, unsigned Q16.8
    localparam int AXIS_W     = 32;   // axis origin and step, unsigned Q20.12
    localparam int LEN_W      = 13;   // trace length register
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Datapath widths. Positions stay below 2^49 for any supported trace length.
    localparam int Z_W     = 49;
    localparam int TFRAC_W = 20;                // extra fraction bits of travel times
    localparam int NUM_W   = 74;                // widest dividend (time-mode numerator)
    localparam int DEN_W   = 70;                // widest divisor (summed travel time)
    localparam int QUO_W   = Z_W + TFRAC_W;     // widest quotient (first travel time)
    localparam int ACC_W   = NUM_W;
    localparam int PROD_W  = AXIS_W + VEL_W;
    localparam int KCNT_W  = 7;

    // Quotient bit counts of the divisions.
    localparam int K_VEL = VEL_W;
    localparam int K_T1  = Z_W + TFRAC_W;
    localparam int K_TS  = AXIS_W + TFRAC_W;

    localparam logic [VEL_W-1:0] VEL_MAX = {VEL_W{1'b1}};

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_MODE    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_ORIGIN  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_STEP    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_TRACE_LENGTH = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_MIN   = CFG_IDX_W'(4);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL_POS,
        ST_ZCUR,
        ST_ZPREV,
        ST_T_MLO,
        ST_T_MHI,
        ST_T_MSTEP,
        ST_T_SUM,
        ST_T_DIV,
        ST_T_WAIT,
        ST_D_T1,
        ST_D_T1_WAIT,
        ST_D_TS,
        ST_D_TS_WAIT,
        ST_D_AVG,
        ST_D_AVG_WAIT,
        ST_FINISH
    } seq_state_t;

    typedef enum logic [1:0] {
        MUL_POS,
        MUL_ZLO,
        MUL_ZHI,
        MUL_STEP
    } mul_sel_t;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD_PROD,
        ACC_ADD_PROD_HI,
        ACC_ADD_PROD,
        ACC_LOAD_QUO,
        ACC_ADD_QUO
    } acc_op_t;

    typedef enum logic [1:0] {
        DIV_AVG_TIME,
        DIV_T1,
        DIV_TS,
        DIV_AVG_DEPTH
    } div_sel_t;

    typedef enum logic [1:0] {
        AVG_HOLD,
        AVG_VINT,
        AVG_QUO,
        AVG_ZERO
    } avg_op_t;

    typedef struct packed {
        logic     stall;
        logic     load_item;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     zc_load;
        logic     zp_load;
        acc_op_t  acc_op;
        logic     div_start;
        div_sel_t div_sel;
        avg_op_t  avg_op;
        logic     finish;
    } ctrl_t;

    typedef struct packed {
        logic sample_valid;
        logic idx_zero;
        logic depth_mode;
        logic prev_zero;
        logic vint_zero;
        logic div_done;
        logic out_free;
    } stat_t;

    typedef struct packed {
        logic              start;
        logic              sat_mode;
        logic [KCNT_W-1:0] k;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic             sat;
        logic [QUO_W-1:0] quo;
    } div_rsp_t;

endpackage

[rtl/avd_div.sv]
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring divider producing one quotient bit per cycle, with an early
// saturation check for velocity quotients.
// ----------------------------------------------------------------------------
module avd_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  avd_pkg::div_req_t             req,
    input  logic [avd_pkg::NUM_W-1:0]     num,
    input  logic [avd_pkg::DEN_W-1:0]     den,
    output avd_pkg::div_rsp_t             rsp
);
    import avd_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              sat_reg,  sat_next;
    logic [KCNT_W-1:0] cnt_reg,  cnt_next;
    logic [DEN_W-1:0]  rem_reg,  rem_next;
    logic [DEN_W-1:0]  den_reg,  den_next;
    logic [NUM_W-1:0]  bits_reg, bits_next;
    logic [QUO_W-1:0]  quo_reg,  quo_next;

    logic [DEN_W+K_VEL-1:0] sat_limit;
    logic [DEN_W+K_VEL-1:0] num_ext;
    logic                   over;
    logic [NUM_W-1:0]       num_shr;
    logic [KCNT_W-1:0]      shl_amt;
    logic [DEN_W:0]         trial;
    logic [DEN_W:0]         diff;
    logic                   ge;

    // A velocity quotient saturates when num >= den * 2^24; a zero divisor
    // falls into the same test.
    assign sat_limit = {den, {K_VEL{1'b0}}};
    assign num_ext   = (DEN_W+K_VEL)'(num);
    assign over      = num_ext >= sat_limit;
    assign num_shr   = num >> req.k;
    assign shl_amt   = KCNT_W'(NUM_W) - req.k;

    assign trial = {rem_reg, bits_reg[NUM_W-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        sat_next  = sat_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        bits_next = bits_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            if (req.sat_mode && over)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                sat_next  = 1'b1;
            end
            else
            begin
                busy_next = 1'b1;
                sat_next  = 1'b0;
                cnt_next  = req.k;
                rem_next  = num_shr[DEN_W-1:0];
                bits_next = num << shl_amt;
                den_next  = den;
                quo_next  = '0;
            end
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_next  = {quo_reg[QUO_W-2:0], ge};
            bits_next = bits_reg << 1;
            cnt_next  = cnt_reg - KCNT_W'(1);
            if (cnt_reg == KCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            sat_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            sat_reg  <= sat_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        bits_reg <= bits_next;
        quo_reg  <= quo_next;
    end

    assign rsp.done = done_reg;
    assign rsp.sat  = sat_reg;
    assign rsp.quo  = quo_reg;

    // A new division is only issued once the previous one has finished.
    a_no_start_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider started while busy");

endmodule

[rtl/avd_ctrl.sv]
// ----------------------------------------------------------------------------
// Conversion sequencer
// Steps one sample through position, product and division phases and
// drives the shared multiplier, accumulator and divider.
// ----------------------------------------------------------------------------
module avd_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  avd_pkg::stat_t stat,
    output avd_pkg::ctrl_t ctrl
);
    import avd_pkg::*;

    seq_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (stat.sample_valid)
                begin
                    state_next = stat.idx_zero ? ST_FINISH : ST_MUL_POS;
                end
            ST_MUL_POS:  state_next = ST_ZCUR;
            ST_ZCUR:     state_next = ST_ZPREV;
            ST_ZPREV:    state_next = stat.depth_mode ? ST_D_T1 : ST_T_MLO;
            ST_T_MLO:    state_next = ST_T_MHI;
            ST_T_MHI:    state_next = ST_T_MSTEP;
            ST_T_MSTEP:  state_next = ST_T_SUM;
            ST_T_SUM:    state_next = ST_T_DIV;
            ST_T_DIV:    state_next = ST_T_WAIT;
            ST_T_WAIT:
                if (stat.div_done)
                begin
                    state_next = ST_FINISH;
                end
            ST_D_T1:     state_next = stat.prev_zero ? ST_FINISH : ST_D_T1_WAIT;
            ST_D_T1_WAIT:
                if (stat.div_done)
                begin
                    state_next = ST_D_TS;
                end
            ST_D_TS:     state_next = stat.vint_zero ? ST_FINISH : ST_D_TS_WAIT;
            ST_D_TS_WAIT:
                if (stat.div_done)
                begin
                    state_next = ST_D_AVG;
                end
            ST_D_AVG:    state_next = ST_D_AVG_WAIT;
            ST_D_AVG_WAIT:
                if (stat.div_done)
                begin
                    state_next = ST_FINISH;
                end
            ST_FINISH:
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl           = '0;
        ctrl.stall     = 1'b1;
        ctrl.mul_sel   = MUL_POS;
        ctrl.acc_op    = ACC_HOLD;
        ctrl.div_sel   = DIV_AVG_TIME;
        ctrl.avg_op    = AVG_HOLD;
        unique case (state_reg)
            ST_IDLE:
            begin
                ctrl.stall = 1'b0;
                if (stat.sample_valid)
                begin
                    ctrl.load_item = 1'b1;
                    if (stat.idx_zero)
                    begin
                        ctrl.avg_op = AVG_VINT;
                    end
                end
            end
            ST_MUL_POS:
            begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = MUL_POS;
            end
            ST_ZCUR:  ctrl.zc_load = 1'b1;
            ST_ZPREV: ctrl.zp_load = 1'b1;
            ST_T_MLO:
            begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = MUL_ZLO;
            end
            ST_T_MHI:
            begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = MUL_ZHI;
                ctrl.acc_op  = ACC_LOAD_PROD;
            end
            ST_T_MSTEP:
            begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = MUL_STEP;
                ctrl.acc_op  = ACC_ADD_PROD_HI;
            end
            ST_T_SUM: ctrl.acc_op = ACC_ADD_PROD;
            ST_T_DIV:
            begin
                ctrl.div_start = 1'b1;
                ctrl.div_sel   = DIV_AVG_TIME;
            end
            ST_T_WAIT:
                if (stat.div_done)
                begin
                    ctrl.avg_op = AVG_QUO;
                end
            ST_D_T1:
                if (stat.prev_zero)
                begin
                    ctrl.avg_op = AVG_ZERO;
                end
                else
                begin
                    ctrl.div_start = 1'b1;
                    ctrl.div_sel   = DIV_T1;
                end
            ST_D_T1_WAIT:
                if (stat.div_done)
                begin
                    ctrl.acc_op = ACC_LOAD_QUO;
                end
            ST_D_TS:
                if (stat.vint_zero)
                begin
                    ctrl.avg_op = AVG_ZERO;
                end
                else
                begin
                    ctrl.div_start = 1'b1;
                    ctrl.div_sel   = DIV_TS;
                end
            ST_D_TS_WAIT:
                if (stat.div_done)
                begin
                    ctrl.acc_op = ACC_ADD_QUO;
                end
            ST_D_AVG:
            begin
                ctrl.div_start = 1'b1;
                ctrl.div_sel   = DIV_AVG_DEPTH;
            end
            ST_D_AVG_WAIT:
                if (stat.div_done)
                begin
                    ctrl.avg_op = AVG_QUO;
                end
            ST_FINISH: ctrl.finish = stat.out_free;
            default:   ctrl.stall  = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/interval_to_average_velocity_top.sv]
// ----------------------------------------------------------------------------
// Interval to average velocity converter
// Turns interval-velocity samples, trace by trace, into average velocities
// in time or depth mode and tracks the running grid minimum and maximum.
// ----------------------------------------------------------------------------
//
// Channel  | Handshake                  | Payload
// ---------+----------------------------+-------------------------------------
// sample   | sample_valid, sample_stall | interval_velocity, grid_start
// result   | result_valid, result_stall | average_velocity, grid_min,
//          |                            | grid_max, trace_end
// config   | cfg_valid, cfg_ready       | cfg_index, cfg_data
//
// One sample is processed at a time; sample_stall stays high until its
// result has been moved into the output register. The shared restoring
// divider, one quotient bit per cycle, sets the cost of a sample.
// The first sample of a trace goes straight to the finish step. Time mode
// runs the position and product setup steps, a 24-bit division and finish.
// Depth mode runs up to three divisions of 69, 52 and 24 quotient bits in a row.
// The result register takes the finished sample even while the previous one
// is still stalled only if that one leaves in the same cycle; otherwise the
// sequencer waits in its finish step. Reset is asynchronous and active low;
// it returns all configuration registers and running values to their
// defaults. No clearing pass is needed after reset.
//
module interval_to_average_velocity_top #(
    parameter int MAX_TRACE_LEN = 4096
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Sample channel.
    input  logic                               sample_valid,
    output logic                               sample_stall,
    input  logic [avd_pkg::VEL_W-1:0]          interval_velocity,
    input  logic                               grid_start,
    // Result channel.
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic [avd_pkg::VEL_W-1:0]          average_velocity,
    output logic [avd_pkg::VEL_W-1:0]          grid_min,
    output logic [avd_pkg::VEL_W-1:0]          grid_max,
    output logic                               trace_end,
    // Configuration write channel.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [avd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [avd_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import avd_pkg::*;

    localparam int IDX_W = $clog2(MAX_TRACE_LEN);
    // Wide enough for the length register and for the index plus one.
    localparam int CMP_W = (IDX_W + 1 > LEN_W) ? IDX_W + 1 : LEN_W;

    // Configuration registers.
    logic              axis_mode_reg,    axis_mode_next;
    logic [AXIS_W-1:0] axis_origin_reg,  axis_origin_next;
    logic [AXIS_W-1:0] axis_step_reg,    axis_step_next;
    logic [LEN_W-1:0]  trace_length_reg, trace_length_next;
    logic [VEL_W-1:0]  header_min_reg,   header_min_next;

    // Running state carried from sample to sample.
    logic [IDX_W-1:0]  idx_reg,     idx_next;
    logic [VEL_W-1:0]  prev_reg,    prev_next;
    logic [VEL_W-1:0]  run_min_reg, run_min_next;
    logic [VEL_W-1:0]  run_max_reg, run_max_next;

    // Working registers of the sample in flight.
    logic [VEL_W-1:0]  vint_reg,    vint_next;
    logic              gstart_reg,  gstart_next;
    logic [PROD_W-1:0] prod_reg,    prod_next;
    logic [Z_W-1:0]    zc_reg,      zc_next;
    logic [Z_W-1:0]    zp_reg,      zp_next;
    logic [ACC_W-1:0]  acc_reg,     acc_next;
    logic [VEL_W-1:0]  avg_reg,     avg_next;

    // Output register.
    logic              res_valid_reg, res_valid_next;
    logic [VEL_W-1:0]  res_avg_reg,   res_avg_next;
    logic [VEL_W-1:0]  res_min_reg,   res_min_next;
    logic [VEL_W-1:0]  res_max_reg,   res_max_next;
    logic              res_end_reg,   res_end_next;

    ctrl_t             ctrl;
    stat_t             stat;
    div_req_t          div_req;
    div_rsp_t          div_rsp;
    logic [NUM_W-1:0]  div_num;
    logic [DEN_W-1:0]  div_den;

    logic [AXIS_W-1:0] mul_a;
    logic [VEL_W-1:0]  mul_b;
    logic [PROD_W-1:0] mul_p;

    logic              out_free;
    logic [CMP_W-1:0]  len_raw;
    logic [CMP_W-1:0]  len_max;
    logic [CMP_W-1:0]  len_eff;
    logic [CMP_W-1:0]  idx_inc;
    logic              is_end;
    logic [VEL_W-1:0]  base_min;
    logic [VEL_W-1:0]  base_max;
    logic [VEL_W-1:0]  quo_vel;

    // ------------------------------------------------------------------
    // Sequencer and shared divider.
    // ------------------------------------------------------------------
    avd_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    avd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .num   (div_num),
        .den   (div_den),
        .rsp   (div_rsp)
    );

    assign out_free = !res_valid_reg || !result_stall;

    assign stat.sample_valid = sample_valid;
    assign stat.idx_zero     = (idx_reg == '0);
    assign stat.depth_mode   = axis_mode_reg;
    assign stat.prev_zero    = (prev_reg == '0);
    assign stat.vint_zero    = (vint_reg == '0);
    assign stat.div_done     = div_rsp.done;
    assign stat.out_free     = out_free;

    // Divider operands. The two velocity divisions run with saturation;
    // the travel-time divisions are only issued with a nonzero divisor.
    always_comb
    begin
        div_req.start = ctrl.div_start;
        unique case (ctrl.div_sel)
            DIV_AVG_TIME:
            begin
                div_req.sat_mode = 1'b1;
                div_req.k        = KCNT_W'(K_VEL);
                div_num          = acc_reg;
                div_den          = DEN_W'(zc_reg);
            end
            DIV_T1:
            begin
                div_req.sat_mode = 1'b0;
                div_req.k        = KCNT_W'(K_T1);
                div_num          = NUM_W'({zp_reg, {TFRAC_W{1'b0}}});
                div_den          = DEN_W'(prev_reg);
            end
            DIV_TS:
            begin
                div_req.sat_mode = 1'b0;
                div_req.k        = KCNT_W'(K_TS);
                div_num          = NUM_W'({axis_step_reg, {TFRAC_W{1'b0}}});
                div_den          = DEN_W'(vint_reg);
            end
            DIV_AVG_DEPTH:
            begin
                div_req.sat_mode = 1'b1;
                div_req.k        = KCNT_W'(K_VEL);
                div_num          = NUM_W'({zc_reg, {TFRAC_W{1'b0}}});
                div_den          = acc_reg[DEN_W-1:0];
            end
            default:
            begin
                div_req.sat_mode = 1'b1;
                div_req.k        = KCNT_W'(K_VEL);
                div_num          = acc_reg;
                div_den          = DEN_W'(zc_reg);
            end
        endcase
    end

    assign quo_vel = div_rsp.sat ? VEL_MAX : div_rsp.quo[VEL_W-1:0];

    // ------------------------------------------------------------------
    // Shared 32x24 multiplier. The 49-bit previous position is taken in a
    // low and a high part, each product registered before it is summed.
    // ------------------------------------------------------------------
    always_comb
    begin
        case (ctrl.mul_sel)
            MUL_POS:
            begin
                mul_a = axis_step_reg;
                mul_b = VEL_W'(idx_reg);
            end
            MUL_ZLO:
            begin
                mul_a = zp_reg[AXIS_W-1:0];
                mul_b = prev_reg;
            end
            MUL_ZHI:
            begin
                mul_a = AXIS_W'(zp_reg[Z_W-1:AXIS_W]);
                mul_b = prev_reg;
            end
            MUL_STEP:
            begin
                mul_a = axis_step_reg;
                mul_b = vint_reg;
            end
            default:
            begin
                mul_a = axis_step_reg;
                mul_b = vint_reg;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // ------------------------------------------------------------------
    // Trace position bookkeeping. A length of zero counts as one and an
    // oversized length is clamped to the supported maximum.
    // ------------------------------------------------------------------
    assign len_raw = CMP_W'(trace_length_reg);
    assign len_max = CMP_W'(MAX_TRACE_LEN);
    assign len_eff = (len_raw == '0) ? CMP_W'(1) :
                     ((len_raw > len_max) ? len_max : len_raw);
    assign idx_inc = CMP_W'(idx_reg) + CMP_W'(1);
    assign is_end  = idx_inc >= len_eff;

    assign base_min = gstart_reg ? header_min_reg : run_min_reg;
    assign base_max = gstart_reg ? header_min_reg : run_max_reg;

    // ------------------------------------------------------------------
    // Next-state logic of the datapath.
    // ------------------------------------------------------------------
    always_comb
    begin
        axis_mode_next    = axis_mode_reg;
        axis_origin_next  = axis_origin_reg;
        axis_step_next    = axis_step_reg;
        trace_length_next = trace_length_reg;
        header_min_next   = header_min_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_AXIS_MODE:    axis_mode_next    = cfg_data[0];
                REG_AXIS_ORIGIN:  axis_origin_next  = cfg_data[AXIS_W-1:0];
                REG_AXIS_STEP:    axis_step_next    = cfg_data[AXIS_W-1:0];
                REG_TRACE_LENGTH: trace_length_next = cfg_data[LEN_W-1:0];
                REG_HEADER_MIN:   header_min_next   = cfg_data[VEL_W-1:0];
                default:          axis_mode_next    = axis_mode_reg;
            endcase
        end
    end

    always_comb
    begin
        vint_next   = vint_reg;
        gstart_next = gstart_reg;
        prod_next   = prod_reg;
        zc_next     = zc_reg;
        zp_next     = zp_reg;
        acc_next    = acc_reg;
        avg_next    = avg_reg;

        if (ctrl.load_item)
        begin
            vint_next   = interval_velocity;
            gstart_next = grid_start;
        end
        if (ctrl.mul_en)
        begin
            prod_next = mul_p;
        end
        if (ctrl.zc_load)
        begin
            zc_next = Z_W'(axis_origin_reg) + Z_W'(prod_reg);
        end
        if (ctrl.zp_load)
        begin
            zp_next = zc_reg - Z_W'(axis_step_reg);
        end

        case (ctrl.acc_op)
            ACC_HOLD:        acc_next = acc_reg;
            ACC_LOAD_PROD:   acc_next = ACC_W'(prod_reg);
            ACC_ADD_PROD_HI: acc_next = acc_reg + ACC_W'({prod_reg, {AXIS_W{1'b0}}});
            ACC_ADD_PROD:    acc_next = acc_reg + ACC_W'(prod_reg);
            ACC_LOAD_QUO:    acc_next = ACC_W'(div_rsp.quo);
            ACC_ADD_QUO:     acc_next = acc_reg + ACC_W'(div_rsp.quo);
            default:         acc_next = acc_reg;
        endcase

        case (ctrl.avg_op)
            AVG_HOLD: avg_next = avg_reg;
            AVG_VINT: avg_next = interval_velocity;
            AVG_QUO:  avg_next = quo_vel;
            AVG_ZERO: avg_next = '0;
            default:  avg_next = avg_reg;
        endcase
    end

    // Commit of a finished sample: running values, index and output register.
    always_comb
    begin
        idx_next       = idx_reg;
        prev_next      = prev_reg;
        run_min_next   = run_min_reg;
        run_max_next   = run_max_reg;
        res_valid_next = res_valid_reg && result_stall;
        res_avg_next   = res_avg_reg;
        res_min_next   = res_min_reg;
        res_max_next   = res_max_reg;
        res_end_next   = res_end_reg;
        if (ctrl.finish)
        begin
            run_min_next   = (avg_reg < base_min) ? avg_reg : base_min;
            run_max_next   = (avg_reg > base_max) ? avg_reg : base_max;
            prev_next      = avg_reg;
            idx_next       = is_end ? '0 : idx_inc[IDX_W-1:0];
            res_valid_next = 1'b1;
            res_avg_next   = avg_reg;
            res_min_next   = run_min_next;
            res_max_next   = run_max_next;
            res_end_next   = is_end;
        end
    end

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_mode_reg    <= 1'b0;
            axis_origin_reg  <= '0;
            axis_step_reg    <= AXIS_W'(4096);
            trace_length_reg <= LEN_W'(1);
            header_min_reg   <= '0;
            idx_reg          <= '0;
            prev_reg         <= '0;
            run_min_reg      <= '0;
            run_max_reg      <= '0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            axis_mode_reg    <= axis_mode_next;
            axis_origin_reg  <= axis_origin_next;
            axis_step_reg    <= axis_step_next;
            trace_length_reg <= trace_length_next;
            header_min_reg   <= header_min_next;
            idx_reg          <= idx_next;
            prev_reg         <= prev_next;
            run_min_reg      <= run_min_next;
            run_max_reg      <= run_max_next;
            res_valid_reg    <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vint_reg    <= vint_next;
        gstart_reg  <= gstart_next;
        prod_reg    <= prod_next;
        zc_reg      <= zc_next;
        zp_reg      <= zp_next;
        acc_reg     <= acc_next;
        avg_reg     <= avg_next;
        res_avg_reg <= res_avg_next;
        res_min_reg <= res_min_next;
        res_max_reg <= res_max_next;
        res_end_reg <= res_end_next;
    end

    // ------------------------------------------------------------------
    // Ports.
    // ------------------------------------------------------------------
    assign sample_stall     = ctrl.stall;
    assign cfg_ready        = 1'b1;
    assign result_valid     = res_valid_reg;
    assign average_velocity = res_avg_reg;
    assign grid_min         = res_min_reg;
    assign grid_max         = res_max_reg;
    assign trace_end        = res_end_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // The running minimum only falls, the maximum only rises, and a reload
    // sets both to the same value, so they never cross.
    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (grid_min <= grid_max))
        else $error("grid minimum above grid maximum");

    // Every delivered average has been folded into the running extremes.
    a_avg_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((average_velocity >= grid_min) &&
                          (average_velocity <= grid_max)))
        else $error("average velocity outside the grid range");

    // Once a sample transfer has been taken, no further sample is accepted
    // in the next cycle.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && !sample_stall) |=> sample_stall)
        else $error("second sample accepted while one is in flight");

endmodule

[dv/interval_to_average_velocity_top_tb.sv]
// ----------------------------------------------------------------------------
// Interval to average velocity converter testbench
// Drives interval-velocity samples trace by trace in time and depth mode,
// predicts every average velocity and the running grid minimum and maximum
// bit for bit, and checks each result transfer against that prediction.
// ----------------------------------------------------------------------------
module interval_to_average_velocity_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import avd_pkg::*;

    localparam int TRACE_LEN_LIMIT = 4096;
    localparam int STALL_LIMIT     = 4000;   // cycles without any transfer
    localparam int SETTLE_CYCLES   = 200;    // longer than one depth-mode sample
    localparam int RESET_CYCLES    = 12;

    // An index that maps to no register; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = CFG_IDX_W'(7);

    typedef struct packed {
        logic [VEL_W-1:0] average;
        logic [VEL_W-1:0] low_mark;
        logic [VEL_W-1:0] high_mark;
        logic             last_in_trace;
    } velocity_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  sample_valid;
    logic                  sample_stall;
    logic [VEL_W-1:0]      interval_velocity;
    logic                  grid_start;
    logic                  result_valid;
    logic                  result_stall;
    logic [VEL_W-1:0]      average_velocity;
    logic [VEL_W-1:0]      grid_min;
    logic [VEL_W-1:0]      grid_max;
    logic                  trace_end;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Shadow copy of the configuration registers.
    logic                 shadow_mode;
    logic [AXIS_W-1:0]    shadow_origin;
    logic [AXIS_W-1:0]    shadow_step;
    logic [LEN_W-1:0]     shadow_length;
    logic [VEL_W-1:0]     shadow_header;

    // Shadow copy of the per-trace state.
    int unsigned          trace_position;
    logic [VEL_W-1:0]     last_average;
    logic [VEL_W-1:0]     floor_value;
    logic [VEL_W-1:0]     ceiling_value;

    velocity_result_t     expected_averages[$];
    int                   mismatch_count = 0;
    int                   idle_cycles = 0;
    bit                   sender_pauses = 1'b0;
    bit                   receiver_pauses = 1'b0;
    int                   stall_burst = 0;
    logic [VEL_W-1:0]     last_velocity = VEL_W'(24'h0A_0000);

    interval_to_average_velocity_top #(
        .MAX_TRACE_LEN (TRACE_LEN_LIMIT)
    ) i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .sample_valid      (sample_valid),
        .sample_stall      (sample_stall),
        .interval_velocity (interval_velocity),
        .grid_start        (grid_start),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .average_velocity  (average_velocity),
        .grid_min          (grid_min),
        .grid_max          (grid_max),
        .trace_end         (trace_end),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Truncating division; a zero divisor yields all ones like the hardware
    // divider does.
    function automatic logic [127:0] divide_down(logic [127:0] dividend,
                                                 logic [127:0] divisor);
        return (divisor == '0) ? '1 : dividend / divisor;
    endfunction

    function automatic logic [VEL_W-1:0] clamp_velocity(logic [127:0] quotient);
        return (quotient > 128'(VEL_MAX)) ? VEL_MAX : quotient[VEL_W-1:0];
    endfunction

    // Computes the result of one sample and advances the shadow state.
    function automatic velocity_result_t predict_average(logic [VEL_W-1:0] vint,
                                                         logic reload);
        int unsigned      span;
        logic [63:0]      z_prev;
        logic [63:0]      z_cur;
        logic [127:0]     weighted;
        logic [127:0]     t_prev;
        logic [127:0]     t_step;
        logic [127:0]     t_total;
        logic [VEL_W-1:0] avg;
        velocity_result_t res;

        // A length of zero acts as one, anything past the limit as the limit.
        span = shadow_length;
        if (span == 0) span = 1;
        if (span > TRACE_LEN_LIMIT) span = TRACE_LEN_LIMIT;

        if (reload) begin
            floor_value   = shadow_header;
            ceiling_value = shadow_header;
        end

        if (trace_position == 0) begin
            avg = vint;
        end else begin
            z_prev = 64'(shadow_origin) + 64'(trace_position - 1) * 64'(shadow_step);
            z_cur  = 64'(shadow_origin) + 64'(trace_position) * 64'(shadow_step);
            if (shadow_mode == 1'b0) begin
                // Time mode: time-weighted mean of the old average and vint.
                weighted = 128'(z_prev) * 128'(last_average)
                         + 128'(shadow_step) * 128'(vint);
                avg = clamp_velocity(divide_down(weighted, 128'(z_cur)));
            end else begin
                // Depth mode: accumulate travel time, then depth over time.
                t_prev  = divide_down(128'(z_prev) << TFRAC_W, 128'(last_average));
                t_step  = divide_down(128'(shadow_step) << TFRAC_W, 128'(vint));
                t_total = t_prev + t_step;
                if (t_total < t_prev) t_total = '1;
                avg = clamp_velocity(divide_down(128'(z_cur) << TFRAC_W, t_total));
            end
        end

        if (avg < floor_value) floor_value = avg;
        if (avg > ceiling_value) ceiling_value = avg;
        last_average = avg;

        res.average       = avg;
        res.low_mark      = floor_value;
        res.high_mark     = ceiling_value;
        res.last_in_trace = (trace_position + 1 >= span);
        trace_position    = res.last_in_trace ? 0 : trace_position + 1;
        return res;
    endfunction

    function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] value);
        case (idx)
            REG_AXIS_MODE:    shadow_mode   = value[0];
            REG_AXIS_ORIGIN:  shadow_origin = value[AXIS_W-1:0];
            REG_AXIS_STEP:    shadow_step   = value[AXIS_W-1:0];
            REG_TRACE_LENGTH: shadow_length = value[LEN_W-1:0];
            REG_HEADER_MIN:   shadow_header = value[VEL_W-1:0];
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Transfers
    // ------------------------------------------------------------------------

    // Sends one sample and records its expected result once it is taken.
    // The valid stays high after the transfer, so back-to-back samples need
    // only one assignment per falling edge.
    task automatic send_sample(input logic [VEL_W-1:0] vint, input logic reload);
        int gap;
        @(negedge clk);
        if (sender_pauses && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            sample_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_valid      = 1'b1;
        interval_velocity = vint;
        grid_start        = reload;
        do @(posedge clk); while (sample_stall);
        expected_averages.push_back(predict_average(vint, reload));
    endtask

    task automatic end_samples();
        @(negedge clk);
        sample_valid = 1'b0;
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge clk); while (!cfg_ready);
        apply_register(idx, value);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Every sample yields exactly one result, so the block is idle as soon as
    // nothing is outstanding; a trailing wait lets the sequencer settle.
    task automatic wait_for_results();
        end_samples();
        while (expected_averages.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Mostly velocities close to the previous one, as in a real velocity
    // model, mixed with extremes and unrelated values.
    function automatic logic [VEL_W-1:0] pick_velocity();
        longint next_value;
        case ($urandom_range(0, 9))
            0:       next_value = longint'(VEL_MAX) - $urandom_range(0, 3);
            1:       next_value = $urandom_range(1, 16);
            2, 3:    next_value = $urandom_range(1, 24'hFF_FFFF);
            4:       next_value = $urandom_range(24'h05_DC00, 24'h17_7000);
            default: next_value = longint'(last_velocity)
                                + longint'($urandom_range(0, 4096)) - 2048;
        endcase
        if (next_value < 1) next_value = 1;
        if (next_value > longint'(VEL_MAX)) next_value = longint'(VEL_MAX);
        last_velocity = VEL_W'(next_value);
        return last_velocity;
    endfunction

    function automatic void pick_pauses(input bit allowed);
        sender_pauses   = allowed && ($urandom_range(0, 2) != 0);
        receiver_pauses = allowed && ($urandom_range(0, 2) != 0);
    endfunction

    // Writes a random setting; the data bits above the length and header fields
    // are random so that masking of narrow registers is exercised too.
    task automatic randomize_setup(input int longest_trace);
        logic [CFG_DATA_W-1:0] value;
        write_register(REG_AXIS_MODE, {$urandom_range(0, 1) == 1} ? 32'h1 : 32'h0);
        case ($urandom_range(0, 4))
            0:       value = '0;
            1:       value = '1;
            2:       value = $urandom_range(0, 32'h0010_0000);
            default: value = $urandom();
        endcase
        write_register(REG_AXIS_ORIGIN, value);
        case ($urandom_range(0, 4))
            0:       value = 32'h1;
            1:       value = '1;
            2:       value = $urandom_range(1, 32'h0000_4000);
            default: value = $urandom_range(1, 32'hFFFF_FFFF);
        endcase
        write_register(REG_AXIS_STEP, value);
        value = $urandom();
        value[LEN_W-1:0] = ($urandom_range(0, 5) == 0) ? LEN_W'(1)
                         : LEN_W'($urandom_range(2, longest_trace));
        write_register(REG_TRACE_LENGTH, value);
        value = $urandom();
        case ($urandom_range(0, 3))
            0:       value[VEL_W-1:0] = '0;
            1:       value[VEL_W-1:0] = VEL_MAX;
            default: value[VEL_W-1:0] = pick_velocity();
        endcase
        write_register(REG_HEADER_MIN, value);
    endtask

    // Sends whole traces: a new grid usually begins at a trace start, with
    // an occasional stray grid start in the middle of a trace.
    task automatic send_traces(input int count);
        logic reload;
        for (int n = 0; n < count; n++) begin
            reload = (trace_position == 0 && $urandom_range(0, 3) == 0)
                  || $urandom_range(0, 19) == 0;
            send_sample(pick_velocity(), reload);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset defaults give one-sample traces, so every sample passes through.
    task automatic test_pass_through();
        pick_pauses(1'b1);
        send_sample(VEL_W'(1), 1'b1);
        send_sample(VEL_MAX, 1'b0);
        send_sample('0, 1'b0);
        send_sample(VEL_W'(24'h80_0000), 1'b1);
        wait_for_results();
    endtask

    task automatic test_time_mode();
        write_register(REG_AXIS_MODE, 32'h0);
        write_register(REG_AXIS_ORIGIN, 32'h0);
        write_register(REG_AXIS_STEP, 32'h0000_1000);
        write_register(REG_TRACE_LENGTH, 32'd4);
        write_register(REG_HEADER_MIN, 32'h0000_0080);
        send_sample(VEL_MAX, 1'b1);
        send_sample(VEL_W'(1), 1'b0);
        send_sample(VEL_MAX, 1'b0);
        send_sample(VEL_W'(1), 1'b0);
        wait_for_results();
        // Largest origin and step: the widest positions and numerator.
        write_register(REG_AXIS_ORIGIN, '1);
        write_register(REG_AXIS_STEP, '1);
        write_register(REG_TRACE_LENGTH, 32'd3);
        write_register(REG_HEADER_MIN, 32'(VEL_MAX));
        send_sample(VEL_MAX, 1'b1);
        send_sample(VEL_MAX, 1'b0);
        send_sample(VEL_W'(1), 1'b0);
        wait_for_results();
    endtask

    task automatic test_depth_mode();
        write_register(REG_AXIS_MODE, 32'h1);
        write_register(REG_AXIS_ORIGIN, 32'h0);
        write_register(REG_AXIS_STEP, 32'h1);
        write_register(REG_HEADER_MIN, 32'h0);
        // With a zero first position and a tiny step both travel times of the second
        // sample are zero, so its velocity division sees a zero divisor and saturates.
        send_sample(VEL_W'(24'h12_3456), 1'b1);
        send_sample(VEL_MAX, 1'b0);
        send_sample(VEL_W'(1), 1'b0);
        wait_for_results();
        // A zero first sample makes the previous average zero, and a zero
        // interval velocity later gives the maximum step time.
        write_register(REG_AXIS_ORIGIN, 32'h0000_1000);
        write_register(REG_AXIS_STEP, 32'h0000_1000);
        send_sample('0, 1'b1);
        send_sample(VEL_W'(24'h00_0100), 1'b0);
        send_sample('0, 1'b0);
        wait_for_results();
    endtask

    task automatic test_length_limits();
        write_register(REG_AXIS_MODE, 32'h0);
        // A zero length behaves as one.
        write_register(REG_TRACE_LENGTH, 32'h0);
        send_sample(VEL_W'(24'h01_0000), 1'b0);
        send_sample(VEL_W'(24'h02_0000), 1'b1);
        wait_for_results();
        // The largest field value is cut down to the trace limit.
        write_register(REG_TRACE_LENGTH, 32'h0000_1FFF);
        write_register(REG_UNMAPPED, '1);
        send_sample(VEL_W'(24'h03_0000), 1'b0);
        send_sample(VEL_W'(24'h04_0000), 1'b0);
        wait_for_results();
        // Shortening the trace to no more than the current position ends it at once.
        write_register(REG_TRACE_LENGTH, 32'd2);
        send_sample(VEL_W'(24'h05_0000), 1'b0);
        wait_for_results();
    endtask

    task automatic test_random_traces(input int phases, input int count,
                                      input bit allowed);
        for (int p = 0; p < phases; p++) begin
            wait_for_results();
            randomize_setup(24);
            pick_pauses(allowed);
            send_traces(count);
        end
        wait_for_results();
    endtask

    // One long trace at the full length; the position climbs far without
    // wrapping, which stresses the widest positions.
    task automatic test_long_trace(input int count);
        logic [CFG_DATA_W-1:0] value;
        wait_for_results();
        randomize_setup(24);
        value = $urandom();
        value[LEN_W-1:0] = LEN_W'(TRACE_LEN_LIMIT);
        write_register(REG_TRACE_LENGTH, value);
        pick_pauses(1'b1);
        send_traces(count);
        wait_for_results();
    endtask

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------

    // Each result transfer is matched against the oldest prediction, field by
    // field; the run carries on after a mismatch.
    always @(posedge clk) begin
        velocity_result_t want;
        if (rst_n && result_valid && !result_stall) begin
            if (expected_averages.size() == 0) begin
                $display("%0t: result with no sample outstanding: avg %h min %h max %h end %b",
                         $time, average_velocity, grid_min, grid_max, trace_end);
                mismatch_count++;
            end else begin
                want = expected_averages.pop_front();
                if (average_velocity !== want.average) begin
                    $display("%0t: average_velocity expected %h actual %h",
                             $time, want.average, average_velocity);
                    mismatch_count++;
                end
                if (grid_min !== want.low_mark) begin
                    $display("%0t: grid_min expected %h actual %h",
                             $time, want.low_mark, grid_min);
                    mismatch_count++;
                end
                if (grid_max !== want.high_mark) begin
                    $display("%0t: grid_max expected %h actual %h",
                             $time, want.high_mark, grid_max);
                    mismatch_count++;
                end
                if (trace_end !== want.last_in_trace) begin
                    $display("%0t: trace_end expected %b actual %b",
                             $time, want.last_in_trace, trace_end);
                    mismatch_count++;
                end
            end
        end
    end

    // The receiver holds off in random bursts whenever pauses are enabled for
    // the current phase.
    always @(negedge clk) begin
        if (stall_burst > 0) begin
            stall_burst  <= stall_burst - 1;
            result_stall <= 1'b1;
        end else if (receiver_pauses && $urandom_range(0, 4) == 0) begin
            stall_burst  <= $urandom_range(0, 5);
            result_stall <= 1'b1;
        end else begin
            result_stall <= 1'b0;
        end
    end

    // Watchdog: a stretch with no transfer on any channel that outlasts even a
    // depth-mode sample means the block has hung.
    always @(posedge clk) begin
        if ((sample_valid && !sample_stall) || (result_valid && !result_stall)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("[interval_to_average_velocity_top] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        rst_n             = 1'b0;
        sample_valid      = 1'b0;
        interval_velocity = '0;
        grid_start        = 1'b0;
        result_stall      = 1'b0;
        cfg_valid         = 1'b0;
        cfg_index         = REG_AXIS_MODE;
        cfg_data          = '0;

        // Shadow state matches the register and state defaults after reset.
        shadow_mode    = 1'b0;
        shadow_origin  = '0;
        shadow_step    = AXIS_W'(32'h0000_1000);
        shadow_length  = LEN_W'(1);
        shadow_header  = '0;
        trace_position = 0;
        last_average   = '0;
        floor_value    = '0;
        ceiling_value  = '0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        test_pass_through();
        test_time_mode();
        test_depth_mode();
        test_length_limits();
        test_random_traces(16, 60, 1'b1);
        test_long_trace(150);
        // The closing phases run without any pauses on either side.
        test_random_traces(4, 60, 1'b0);

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_averages.size() == 0) begin
            $display("[interval_to_average_velocity_top] OK");
        end else begin
            $display("[interval_to_average_velocity_top] ERROR");
        end
        $finish;
    end

endmodule

[interval_to_average_velocity_top.f]
rtl/avd_pkg.sv
rtl/avd_div.sv
rtl/avd_ctrl.sv
rtl/interval_to_average_velocity_top.sv
dv/interval_to_average_velocity_top_tb.sv
